// ----- design/bpa_pkg.sv -----
// Shared types, constants and helpers for the bitmap page allocator.
package bpa_pkg;

	localparam int ADDR_W      = 48;
	localparam int POOL_PAGES  = 4096;
	localparam int PAGE_BYTES  = 4096;
	localparam int WORD_BITS   = 64;
	localparam int NUM_WORDS   = (POOL_PAGES + WORD_BITS - 1) / WORD_BITS;
	localparam int WORD_IDX_W  = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int BIT_IDX_W   = $clog2(WORD_BITS);
	localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
	localparam int POOL_PAGE_W = $clog2(POOL_PAGES);
	localparam longint unsigned POOL_BYTES =
		longint'(POOL_PAGES) * longint'(PAGE_BYTES);

	typedef enum logic [0:0] {
		ACT_ALLOC = 1'b0,
		ACT_FREE  = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		STAT_DONE    = 2'd0,
		STAT_EMPTY   = 2'd1,
		STAT_OUTSIDE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_GRANT,
		ST_FREE
	} state_t;

	typedef struct packed {
		action_t             action;
		logic [ADDR_W-1:0]   page_address;
	} request_t;

	typedef struct packed {
		logic [ADDR_W-1:0]   granted_address;
		status_t             status;
	} result_t;

	// Bits of a bitmap word that stand for pages inside the pool.
	function automatic logic [WORD_BITS-1:0] valid_mask(input logic [WORD_IDX_W-1:0] word);
		logic [WORD_BITS-1:0] mask;
		int unsigned first;
		mask  = '0;
		first = int'(word) * WORD_BITS;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (first + i < POOL_PAGES)
				mask[i] = 1'b1;
		end
		return mask;
	endfunction

endpackage

// ----- design/bitmap_page_allocator_core.sv -----
// Bitmap page allocator core: first-fit allocate and free over a used-page bitmap RAM.
// Allocate: the scan reads the words in order from word 0, stops at the first one holding a
//   free page and raises the strobe from ST_GRANT; a full pool reports after the last word.
// Free: reads the word and clears the bit in ST_FREE; an outside address reports from idle.
// The scan issues one bitmap RAM read per cycle; a new request is taken in the strobe cycle.
// Reset clears per-word valid flags at once, so the whole pool reads as free; base is 0.
module bitmap_page_allocator_core
	import bpa_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  request_t            request,
	input  logic                cfg_we,
	input  logic [ADDR_W-1:0]   cfg_wdata,
	output logic                done,
	output result_t             result
);

	state_t                  state_q, state_d;
	logic [ADDR_W-1:0]       base_q;
	logic [WORD_IDX_W-1:0]   word_q, word_d;
	logic [BIT_IDX_W-1:0]    bit_q, bit_d;
	logic [NUM_WORDS-1:0]    valid_q;
	logic                    done_q, done_d;
	result_t                 result_q, result_d;

	logic                    ram_we;
	logic [WORD_IDX_W-1:0]   ram_raddr;
	logic [WORD_BITS-1:0]    ram_wdata, ram_rdata, rword;

	logic [ADDR_W-1:0]       offset;
	logic                    outside;
	logic [POOL_PAGE_W-1:0]  rel_page;
	logic [WORD_BITS-1:0]    avail, lowest;
	logic [BIT_IDX_W-1:0]    lowest_idx;
	logic [ADDR_W-1:0]       grant_page;

	bpa_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(NUM_WORDS)
	) u_bitmap (
		.clk   (clk),
		.we    (ram_we),
		.waddr (word_q),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// A word never written since reset reads as all free.
	assign rword = valid_q[word_q] ? ram_rdata : '0;

	assign offset   = request.page_address - base_q;
	assign outside  = {16'b0, offset} >= POOL_BYTES;
	assign rel_page = offset[PAGE_SHIFT +: POOL_PAGE_W];

	assign avail  = ~rword & valid_mask(word_q);
	assign lowest = avail & (~avail + 1'b1);

	always_comb begin
		lowest_idx = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (lowest[i])
				lowest_idx = lowest_idx | BIT_IDX_W'(i);
		end
	end

	assign grant_page = ADDR_W'({word_q, bit_q});

	always_comb begin
		state_d   = state_q;
		word_d    = word_q;
		bit_d     = bit_q;
		done_d    = 1'b0;
		result_d  = result_q;
		ram_we    = 1'b0;
		ram_raddr = word_q;
		ram_wdata = rword;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (request.action == ACT_ALLOC) begin
						ram_raddr = '0;
						word_d    = '0;
						state_d   = ST_SCAN;
					end else if (outside) begin
						done_d   = 1'b1;
						result_d = '{granted_address: '0, status: STAT_OUTSIDE};
					end else begin
						ram_raddr = WORD_IDX_W'(rel_page / WORD_BITS);
						word_d    = WORD_IDX_W'(rel_page / WORD_BITS);
						bit_d     = BIT_IDX_W'(rel_page % WORD_BITS);
						state_d   = ST_FREE;
					end
				end
			end
			ST_SCAN: begin
				// Read the next word ahead; drop it on a hit.
				ram_raddr = word_q + 1'b1;
				if (avail != '0) begin
					ram_we    = 1'b1;
					ram_wdata = rword | lowest;
					bit_d     = lowest_idx;
					state_d   = ST_GRANT;
				end else if (word_q == WORD_IDX_W'(NUM_WORDS - 1)) begin
					done_d   = 1'b1;
					result_d = '{granted_address: '0, status: STAT_EMPTY};
					state_d  = ST_IDLE;
				end else begin
					word_d = word_q + 1'b1;
				end
			end
			ST_GRANT: begin
				done_d   = 1'b1;
				result_d = '{granted_address: base_q + (grant_page << PAGE_SHIFT),
				             status: STAT_DONE};
				state_d  = ST_IDLE;
			end
			ST_FREE: begin
				ram_we    = 1'b1;
				ram_wdata = rword & ~(WORD_BITS'(1) << bit_q);
				done_d    = 1'b1;
				result_d  = '{granted_address: '0, status: STAT_DONE};
				state_d   = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			valid_q <= '0;
			base_q  <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			if (ram_we)
				valid_q[word_q] <= 1'b1;
			if (cfg_we)
				base_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		word_q   <= word_d;
		bit_q    <= bit_d;
		result_q <= result_d;
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

	a_done_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == ST_IDLE)
		else $error("result strobe while a request is still in progress");

	a_empty_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && result_q.status != STAT_DONE) |-> result_q.granted_address == '0)
		else $error("failed request returned a nonzero address");

	a_alloc_sets_one: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && state_q == ST_SCAN) |->
		$countones(ram_wdata) == $countones(rword) + 1)
		else $error("allocate write-back did not set exactly one free bit");

	a_grant_follows_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_GRANT) |-> $past(ram_we))
		else $error("grant without bitmap update");

endmodule

// ----- design/bpa_ram.sv -----
// Generic single-port-write, registered-read RAM.
module bpa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// ----- sim/bitmap_page_allocator_core_tb.sv -----
// Self-checking testbench for the bitmap page allocator core.
`timescale 1ns / 1ps

module bitmap_page_allocator_core_tb
	import bpa_pkg::*;
();

	localparam int CYCLE_LIMIT = 2000000;
	localparam int TAIL_CYCLES = 80;
	localparam logic [ADDR_W-1:0] POOL_SPAN = ADDR_W'(POOL_BYTES);

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	request_t            request = '0;
	logic                cfg_we = 1'b0;
	logic [ADDR_W-1:0]   cfg_wdata = '0;
	logic                done;
	result_t             result;

	bitmap_page_allocator_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.request   (request),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.done      (done),
		.result    (result)
	);

	// Shadow of the block: used-page bits and the pool base.
	bit [POOL_PAGES-1:0]  shadow_used = '0;
	logic [ADDR_W-1:0]    shadow_base = '0;

	request_t  pending_requests[$];
	result_t   expected_results[$];
	result_t   want;
	int        sent_cnt = 0;
	int        accepted_cnt = 0;
	int        err_count = 0;
	int        cycle_cnt = 0;
	int        fill_guess = 0;

	int        burst_left = 4;
	int        gap_left = 0;
	int        burst_no = 0;
	bit        draining = 1'b0;

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic logic [ADDR_W-1:0] rnd48();
		logic [ADDR_W-1:0] v;
		v = ADDR_W'({$urandom, $urandom});
		return v;
	endfunction

	// First fit on allocate, bit clear on free; updates the shadow bitmap.
	function automatic result_t grant_or_release(request_t req);
		result_t           r;
		logic [ADDR_W-1:0] off;
		logic [ADDR_W-1:0] poff;
		bit                found;
		int unsigned       page;
		r.granted_address = '0;
		r.status = STAT_DONE;
		found = 1'b0;
		if (req.action == ACT_ALLOC) begin
			for (int p = 0; p < POOL_PAGES && !found; p++) begin
				if (!shadow_used[p]) begin
					shadow_used[p] = 1'b1;
					poff = ADDR_W'(p);
					poff = poff << PAGE_SHIFT;
					r.granted_address = shadow_base + poff;
					found = 1'b1;
				end
			end
			if (!found)
				r.status = STAT_EMPTY;
		end else begin
			off = req.page_address - shadow_base;
			if (off >= POOL_BYTES) begin
				r.status = STAT_OUTSIDE;
			end else begin
				page = 32'(off >> PAGE_SHIFT);
				shadow_used[page] = 1'b0;
			end
		end
		return r;
	endfunction

	// Predict on every transfer, check every strobe.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				shadow_base = cfg_wdata;
			if (done) begin
				if (expected_results.size() == 0) begin
					$error("result with nothing outstanding: granted_address %h status %0d",
						result.granted_address, result.status);
					err_count++;
				end else begin
					want = expected_results.pop_front();
					if (result.granted_address !== want.granted_address) begin
						$error("granted_address: expected %h, actual %h",
							want.granted_address, result.granted_address);
						err_count++;
					end
					if (result.status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, result.status);
						err_count++;
					end
				end
			end
			if (start && !busy) begin
				expected_results.push_back(grant_or_release(request));
				accepted_cnt <= accepted_cnt + 1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("bitmap_page_allocator_core_tb failed");
			$finish;
		end
	end

	// Request driver: bursts, random gaps, and now and then a full drain.
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (start && accepted_cnt != sent_cnt) begin
			// hold until the transfer happens
		end else if (draining) begin
			start <= 1'b0;
			if (expected_results.size() == 0 && !busy)
				draining <= 1'b0;
		end else if (gap_left > 0) begin
			start <= 1'b0;
			gap_left <= gap_left - 1;
		end else if (pending_requests.size() > 0) begin
			request <= pending_requests.pop_front();
			start <= 1'b1;
			sent_cnt <= sent_cnt + 1;
			if (burst_left <= 1) begin
				burst_no++;
				burst_left <= $urandom_range(1, 40);
				gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
				if (burst_no % 37 == 5)
					draining <= 1'b1;
			end else begin
				burst_left <= burst_left - 1;
			end
		end else begin
			start <= 1'b0;
		end
	end

	task automatic push_req(input action_t act, input logic [ADDR_W-1:0] addr);
		request_t r;
		r.action = act;
		r.page_address = addr;
		pending_requests.push_back(r);
		if (act == ACT_ALLOC) begin
			if (fill_guess < POOL_PAGES)
				fill_guess++;
		end else if (fill_guess > 0) begin
			fill_guess--;
		end
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_requests.size() != 0 || start || expected_results.size() != 0 || busy);
	endtask

	task automatic write_pool_base(input logic [ADDR_W-1:0] value);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Allocates at alloc_pct percent; frees mostly of pages likely in use, plus edges and noise.
	task automatic queue_random(input int count, input int alloc_pct,
			input logic [ADDR_W-1:0] base);
		logic [ADDR_W-1:0] addr;
		logic [ADDR_W-1:0] poff;
		int                sel;
		int                top;
		for (int i = 0; i < count; i++) begin
			top = (fill_guess + 8 > POOL_PAGES - 1) ? POOL_PAGES - 1 : fill_guess + 8;
			poff = ADDR_W'($urandom_range(0, top));
			poff = poff << PAGE_SHIFT;
			sel = $urandom_range(0, 99);
			if (sel < 55) begin
				addr = base + poff;
			end else if (sel < 75) begin
				addr = base + poff + ADDR_W'($urandom_range(1, PAGE_BYTES - 1));
			end else if (sel < 85) begin
				case ($urandom_range(0, 3))
					0: begin
						addr = base - 1'b1;
					end
					1: begin
						addr = base + POOL_SPAN;
					end
					2: begin
						addr = base + POOL_SPAN - 1'b1;
					end
					default: begin
						addr = base;
					end
				endcase
			end else begin
				addr = rnd48();
			end
			if ($urandom_range(0, 99) < alloc_pct)
				push_req(ACT_ALLOC, rnd48());
			else
				push_req(ACT_FREE, addr);
		end
	endtask

	initial begin
		logic [ADDR_W-1:0] base;

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Base 0 after reset: page 0 granted at address 0, double free,
		// unaligned free, addresses just past the pool and at the top.
		push_req(ACT_ALLOC, '0);
		push_req(ACT_ALLOC, '1);
		push_req(ACT_ALLOC, 48'h5555_5555_5555);
		push_req(ACT_FREE, 48'h0);
		push_req(ACT_FREE, 48'h0);
		push_req(ACT_FREE, 48'h1FFF);
		push_req(ACT_FREE, POOL_SPAN);
		push_req(ACT_FREE, POOL_SPAN - 1'b1);
		push_req(ACT_FREE, 48'hFFFF_FFFF_FFFF);
		push_req(ACT_ALLOC, 48'hAAAA_AAAA_AAAA);
		push_req(ACT_ALLOC, '0);

		// Highest aligned base: granted addresses wrap past the top.
		write_pool_base(48'hFFFF_FFFF_F000);
		push_req(ACT_ALLOC, '0);
		push_req(ACT_FREE, 48'h0000_0000_0FFF);
		push_req(ACT_FREE, 48'hFFFF_FFFF_EFFF);
		push_req(ACT_FREE, 48'hFFFF_FFFF_FFFF);
		push_req(ACT_ALLOC, '0);
		push_req(ACT_ALLOC, '0);

		// All-ones base, not page aligned.
		write_pool_base(48'hFFFF_FFFF_FFFF);
		push_req(ACT_ALLOC, '0);
		push_req(ACT_FREE, 48'h0);
		push_req(ACT_FREE, 48'hFFFF_FFFF_FFFE);
		push_req(ACT_ALLOC, '0);

		write_pool_base('0);
		queue_random(300, 70, '0);

		base = rnd48();
		base[PAGE_SHIFT-1:0] = '0;
		write_pool_base(base);
		queue_random(300, 50, base);

		write_pool_base(48'hFFFF_FFFF_F000);
		queue_random(250, 60, 48'hFFFF_FFFF_F000);

		base = rnd48();
		write_pool_base(base);
		queue_random(200, 50, base);

		// Push the fill deep into the bitmap, then churn on long scans.
		base = rnd48();
		base[PAGE_SHIFT-1:0] = '0;
		write_pool_base(base);
		for (int i = 0; i < 600; i++)
			push_req(ACT_ALLOC, rnd48());
		queue_random(200, 50, base);

		write_pool_base('0);
		queue_random(80, 30, '0);

		wait_drained();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (err_count == 0 && expected_results.size() == 0)
			$display("bitmap_page_allocator_core_tb passed");
		else
			$display("bitmap_page_allocator_core_tb failed");
		$finish;
	end

endmodule
